@@ rtl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// shared constants and handshake types for the point-in-polygon test block
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    localparam int MAX_VERTS_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int IDX_W          = 6;   // vert_index field width
    localparam int CFG_W          = 7;   // vertex_count register width
    localparam int OUT_TDATA_W    = 8;

    localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(3);

    // op codes carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // control from the sequencer to the edge unit
    typedef struct packed {
        logic start;   // new test point, clear parity
        logic issue;   // an edge enters the pipeline this cycle
    } edge_ctl_t;

    // status back from the edge unit
    typedef struct packed {
        logic busy;    // edges still in flight
        logic parity;  // running even-odd parity
    } edge_sts_t;

endpackage

`default_nettype wire

@@ rtl/pip_cell.sv @@
// ----------------------------------------------------------------------------
// pip_cell
// one vertex slot of the rotating vertex ring
// ----------------------------------------------------------------------------
`default_nettype none

module pip_cell
    import pip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  wire                         aclk,
    input  wire                         load_en,
    input  wire        [IDX_W-1:0]      load_idx,
    input  wire signed [COORD_BITS-1:0] load_x,
    input  wire signed [COORD_BITS-1:0] load_y,
    input  wire                         shift_en,
    input  wire signed [COORD_BITS-1:0] nbr_x,
    input  wire signed [COORD_BITS-1:0] nbr_y,
    output logic signed [COORD_BITS-1:0] x_out,
    output logic signed [COORD_BITS-1:0] y_out
);

    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic                         hit;

    // slot match, compared at full int width so high slots never alias
    assign hit = load_en && (32'(load_idx) == CELL_IDX);

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            x_reg <= nbr_x;
            y_reg <= nbr_y;
        end else if (hit) begin
            x_reg <= load_x;
            y_reg <= load_y;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

`default_nettype wire

@@ rtl/pip_edge.sv @@
// ----------------------------------------------------------------------------
// pip_edge
// edge crossing test (differences, then products) with even-odd parity accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge
    import pip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  edge_ctl_t                    ctl,
    input  wire signed [COORD_BITS-1:0]  xi,
    input  wire signed [COORD_BITS-1:0]  yi,
    input  wire signed [COORD_BITS-1:0]  xj,
    input  wire signed [COORD_BITS-1:0]  yj,
    input  wire signed [COORD_BITS-1:0]  tx,
    input  wire signed [COORD_BITS-1:0]  ty,
    output edge_sts_t                    sts
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // stage 1: differences
    logic                 v1_reg, str1_reg, pos1_reg;
    logic signed [DW-1:0] a_reg, dy_reg, b_reg, c_reg;
    // stage 2: products
    logic                 v2_reg, str2_reg, pos2_reg;
    logic signed [PW-1:0] pl_reg, pr_reg;
    logic                 parity_reg;

    logic straddle, dy_pos, left;

    assign straddle = (yi > ty) != (yj > ty);
    assign dy_pos   = yj > yi;
    // point strictly left of the crossing, sign of dy folded into the compare
    assign left     = pos2_reg ? (pl_reg < pr_reg) : (pr_reg < pl_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            parity_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            if (ctl.start) begin
                parity_reg <= 1'b0;
            end else if (v2_reg && str2_reg && left) begin
                parity_reg <= !parity_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        str1_reg <= straddle;
        pos1_reg <= dy_pos;
        a_reg    <= DW'(tx) - DW'(xi);
        dy_reg   <= DW'(yj) - DW'(yi);
        b_reg    <= DW'(xj) - DW'(xi);
        c_reg    <= DW'(ty) - DW'(yi);
        str2_reg <= str1_reg;
        pos2_reg <= pos1_reg;
        pl_reg   <= PW'(a_reg) * PW'(dy_reg);
        pr_reg   <= PW'(b_reg) * PW'(c_reg);
    end

    assign sts.busy   = v1_reg || v2_reg;
    assign sts.parity = parity_reg;

endmodule

`default_nettype wire

@@ rtl/point_in_polygon_test_top.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// even-odd ray casting point-in-polygon test over a rotating vertex ring
// ----------------------------------------------------------------------------
// load transaction: block stays idle, next transaction may follow at once
// test transaction: the vertex ring makes one full turn, feeding at most one
//   edge per cycle into the edge unit, then the closing edge follows
// one test at a time; loads and tests are taken again once the result is
//   staged in the output register, even while it waits for m_tready
// reset (aresetn low, synchronous) clears control and sets vertex_count to 3;
//   vertex slots hold no defined value until loaded
`default_nettype none

module point_in_polygon_test_top
    import pip_pkg::*;
#(
    parameter int MAX_VERTS  = MAX_VERTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // input stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // vert_index [IDX_W-1:0], coord_x, coord_y, zero fill
    input  wire [((IDX_W+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // op
    input  wire [0:0]                          s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // inside_res, zero fill
    output logic [OUT_TDATA_W-1:0]             m_tdata,
    // vertex_count register
    input  wire                                cfg_we,
    input  wire [CFG_W-1:0]                    cfg_wdata
);

    localparam int KW = $clog2(MAX_VERTS) + 1;        // ring position counter
    localparam int NW = (KW > CFG_W) ? KW : CFG_W;    // effective vertex count

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,     // ring turning, edges issued
        ST_CLOSE,   // closing edge from last vertex back to vertex 0
        ST_DRAIN,   // edge pipeline empties
        ST_FINISH   // parity moved to the output register
    } state_t;

    state_t           state_reg, state_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [CFG_W-1:0] vcount_reg, vcount_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             inside_reg;

    // test point and carried vertices
    logic signed [COORD_BITS-1:0] tx_reg, ty_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;

    // unpacked input fields
    logic        [IDX_W-1:0]      in_idx;
    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic                         in_acc, load_acc, test_acc;

    // ring
    logic signed [COORD_BITS-1:0] ring_x [MAX_VERTS];
    logic signed [COORD_BITS-1:0] ring_y [MAX_VERTS];
    logic                         ring_shift;

    logic [NW-1:0] n_eff;
    logic          k_live;       // head vertex is in use
    logic          finish_load;

    edge_ctl_t                    e_ctl;
    edge_sts_t                    e_sts;
    logic signed [COORD_BITS-1:0] e_xi, e_yi;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_x   = s_tdata[IDX_W +: COORD_BITS];
    assign in_y   = s_tdata[IDX_W+COORD_BITS +: COORD_BITS];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign load_acc = in_acc && (s_tuser[0] == OP_LOAD);
    assign test_acc = in_acc && (s_tuser[0] == OP_TEST);

    // count above the store saturates
    assign n_eff = (NW'(vcount_reg) > NW'(MAX_VERTS)) ? NW'(MAX_VERTS) : NW'(vcount_reg);
    assign k_live = (NW'(k_reg) < n_eff);

    assign ring_shift = (state_reg == ST_RUN);

    // vertex ring: slot i takes slot i+1, slot 0 is the head
    for (genvar gi = 0; gi < MAX_VERTS; gi++) begin : g_cell
        localparam int NB = (gi + 1) % MAX_VERTS;
        pip_cell #(
            .COORD_BITS (COORD_BITS),
            .CELL_IDX   (gi)
        ) u_cell (
            .aclk     (aclk),
            .load_en  (load_acc),
            .load_idx (in_idx),
            .load_x   (in_x),
            .load_y   (in_y),
            .shift_en (ring_shift),
            .nbr_x    (ring_x[NB]),
            .nbr_y    (ring_y[NB]),
            .x_out    (ring_x[gi]),
            .y_out    (ring_y[gi])
        );
    end

    // edge (k, k-1) while turning; closing edge (0, n-1) afterwards
    always_comb begin
        e_ctl.start = test_acc;
        e_ctl.issue = 1'b0;
        e_xi        = ring_x[0];
        e_yi        = ring_y[0];
        if (state_reg == ST_RUN) begin
            e_ctl.issue = k_live && (k_reg != '0);
        end else if (state_reg == ST_CLOSE) begin
            e_ctl.issue = (n_eff != '0);
            e_xi        = first_x_reg;
            e_yi        = first_y_reg;
        end
    end

    pip_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (e_ctl),
        .xi      (e_xi),
        .yi      (e_yi),
        .xj      (prev_x_reg),
        .yj      (prev_y_reg),
        .tx      (tx_reg),
        .ty      (ty_reg),
        .sts     (e_sts)
    );

    assign finish_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        vcount_next   = cfg_we ? cfg_wdata : vcount_reg;
        m_tvalid_next = (m_tvalid_reg && !m_tready) || finish_load;
        case (state_reg)
            ST_IDLE: begin
                k_next = '0;
                if (test_acc) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                k_next = k_reg + KW'(1);
                if (k_reg == KW'(MAX_VERTS - 1)) begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!e_sts.busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (finish_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            vcount_reg   <= VCOUNT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            vcount_reg   <= vcount_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (test_acc) begin
            tx_reg <= in_x;
            ty_reg <= in_y;
        end
        if (ring_shift && k_live) begin
            prev_x_reg <= ring_x[0];
            prev_y_reg <= ring_y[0];
            if (k_reg == '0) begin
                first_x_reg <= ring_x[0];
                first_y_reg <= ring_y[0];
            end
        end
        if (finish_load) begin
            inside_reg <= e_sts.parity;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, inside_reg};

endmodule

`default_nettype wire

@@ rtl/pip_checker.sv @@
// ----------------------------------------------------------------------------
// pip_checker
// port-level checks for the point-in-polygon test block
// ----------------------------------------------------------------------------
`default_nettype none

module pip_checker
    import pip_pkg::*;
#(
    parameter int S_TDATA_W = 40
) (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire [S_TDATA_W-1:0]   s_tdata,
    input wire [0:0]             s_tuser,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [OUT_TDATA_W-1:0] m_tdata
);

    logic test_acc, load_acc;

    assign test_acc = s_tvalid && s_tready && (s_tuser[0] == OP_TEST);
    assign load_acc = s_tvalid && s_tready && (s_tuser[0] == OP_LOAD) && (s_tdata != '1);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a test transaction occupies the block
    a_test_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        test_acc |=> !s_tready && !$rose(m_tvalid))
        else $error("input taken or result shown right after a test");

    // a load transaction leaves the block ready and makes no result
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == OP_LOAD)) |=> s_tready && !$rose(m_tvalid))
        else $error("load transaction disturbed the block");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // result carries only the inside flag, except in a cycle that accepts a load whose tdata is not all ones
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:1] == '0) || load_acc)
        else $error("result fill bits set");

endmodule

bind point_in_polygon_test_top pip_checker #(
    .S_TDATA_W (((IDX_W + 2 * COORD_BITS + 7) / 8) * 8)
) u_pip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/pip_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pip_scoreboard
// watches the load/test stream and the result stream of the point-in-polygon
// block, keeps its own vertex store and vertex count, predicts the even-odd
// answer of every accepted test and compares it with the results in order
// ----------------------------------------------------------------------------

module pip_scoreboard
    import pip_pkg::*;
#(
    parameter int S_TDATA_W = ((IDX_W + 2*COORD_BITS_DEF + 7) / 8) * 8
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    input  wire                   s_tready,
    input  wire [S_TDATA_W-1:0]   s_tdata,
    input  wire [0:0]             s_tuser,
    input  wire                   m_tvalid,
    input  wire                   m_tready,
    input  wire [OUT_TDATA_W-1:0] m_tdata,
    input  wire                   cfg_we,
    input  wire [CFG_W-1:0]       cfg_wdata,
    output int                    errors,
    output int                    pending,
    output int                    loads_seen,
    output int                    tests_seen,
    output int                    inside_seen
);

    typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

    typedef struct {
        coord_t px;
        coord_t py;
        logic   exp_res;
    } inside_exp_t;

    coord_t           vx_mem [MAX_VERTS_DEF];
    coord_t           vy_mem [MAX_VERTS_DEF];
    logic [CFG_W-1:0] vcount;
    inside_exp_t      inside_expected [$];

    // exact crossing test: cross-multiplied, sign of dy picks the direction
    function automatic logic predict_inside(input coord_t px, input coord_t py);
        int     n;
        int     j;
        logic   parity;
        longint xi, yi, xj, yj, dy, lhs, rhs;
        n      = (vcount > MAX_VERTS_DEF) ? MAX_VERTS_DEF : int'(vcount);
        parity = 1'b0;
        for (int i = 0; i < n; i++) begin
            j  = (i == 0) ? n - 1 : i - 1;
            xi = vx_mem[i];
            yi = vy_mem[i];
            xj = vx_mem[j];
            yj = vy_mem[j];
            if ((yi > py) != (yj > py)) begin
                dy  = yj - yi;
                lhs = (px - xi) * dy;
                rhs = (xj - xi) * (py - yi);
                if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                    parity = ~parity;
            end
        end
        return parity;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: ERROR %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        inside_exp_t e;
        coord_t      cx, cy;
        if (!aresetn) begin
            vcount = VCOUNT_RESET;
            inside_expected.delete();
            errors      = 0;
            loads_seen  = 0;
            tests_seen  = 0;
            inside_seen = 0;
        end else begin
            if (cfg_we)
                vcount = cfg_wdata;
            if (s_tvalid && s_tready) begin
                cx = s_tdata[IDX_W +: COORD_BITS_DEF];
                cy = s_tdata[IDX_W + COORD_BITS_DEF +: COORD_BITS_DEF];
                if (s_tuser[0] == OP_LOAD) begin
                    vx_mem[s_tdata[IDX_W-1:0]] = cx;
                    vy_mem[s_tdata[IDX_W-1:0]] = cy;
                    loads_seen++;
                end else begin
                    e.px      = cx;
                    e.py      = cy;
                    e.exp_res = predict_inside(cx, cy);
                    inside_expected.push_back(e);
                    tests_seen++;
                    if (e.exp_res)
                        inside_seen++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (inside_expected.size() == 0) begin
                    report_mismatch($sformatf("result %b with no test outstanding",
                                              m_tdata[0]));
                end else begin
                    e = inside_expected.pop_front();
                    if (m_tdata[0] !== e.exp_res)
                        report_mismatch($sformatf(
                            "inside_res for point (%0d,%0d) count %0d: got %b, want %b",
                            e.px, e.py, vcount, m_tdata[0], e.exp_res));
                end
            end
        end
        pending <= inside_expected.size();
    end

endmodule

@@ tb/sv/tb_point_in_polygon_test_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test_top
// drives vertex loads and point tests into the point-in-polygon block over a
// range of vertex counts, with random gaps on both streams and one long
// result back-pressure stretch; pip_scoreboard predicts and compares results
// ----------------------------------------------------------------------------

module tb_point_in_polygon_test_top;
    import pip_pkg::*;

    localparam int S_TDATA_W       = ((IDX_W + 2*COORD_BITS_DEF + 7) / 8) * 8;
    // one test walks the whole vertex ring plus the edge pipeline, with margin
    localparam int LAT_PAUSE       = MAX_VERTS_DEF + 5 + 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int TESTS_PER_PHASE = 18;
    localparam int N_PHASES        = 16;

    typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // vert_index [5:0], coord_x [21:6], coord_y [37:22], zero fill
    logic [S_TDATA_W-1:0]   s_tdata;
    // op
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // inside_res [0], zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_W-1:0]       cfg_wdata;

    int chk_errors, chk_pending, chk_loads, chk_tests, chk_inside;

    // stimulus side bookkeeping: current polygon as the sender knows it
    coord_t pv_x [MAX_VERTS_DEF];
    coord_t pv_y [MAX_VERTS_DEF];
    int     box_cx, box_cy, box_r;
    int     filled;          // slots 0..filled-1 have been loaded since reset
    int     tx_gappy, tx_mode_left;
    int     phases_run;
    bit     hold_req;
    logic   rx_hold;

    // vertex counts per phase: extremes, saturation above the store, tiny counts
    int phase_counts [N_PHASES] = '{4, 64, 127, 0, 1, 2, 3, 65, 5, 8, 12, 6, 100, 20, 3, 7};

    point_in_polygon_test_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    pip_scoreboard #(.S_TDATA_W(S_TDATA_W)) u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .errors      (chk_errors),
        .pending     (chk_pending),
        .loads_seen  (chk_loads),
        .tests_seen  (chk_tests),
        .inside_seen (chk_inside)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("timeout: block stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random wait before each transaction, in stretches with and
    // without gaps; rx_hold overrides everything during the back-pressure test
    initial begin
        int rx_wait;
        int rx_mode_left;
        int rx_gappy;
        m_tready     <= 1'b0;
        rx_wait      = 0;
        rx_mode_left = 0;
        rx_gappy     = 1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (rx_mode_left == 0) begin
                    rx_gappy     = ($urandom_range(0, 3) != 0);
                    rx_mode_left = $urandom_range(10, 40);
                end
                rx_mode_left--;
                rx_wait = rx_gappy ? $urandom_range(0, 19) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= aresetn && !rx_hold && (rx_wait == 0);
        end
    end

    // long hold-off of the result stream, counted here once requested
    initial begin
        rx_hold <= 1'b0;
        wait (hold_req);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // random coordinate around c, clipped to the Q12.4 range
    function automatic coord_t near(input int c, input int r);
        int v;
        v = c + int'($urandom_range(0, 2 * r)) - r;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    // one input transaction; valid stays high across back-to-back items
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input coord_t x, input coord_t y);
        int gap;
        if (tx_mode_left <= 0) begin
            tx_gappy     = ($urandom_range(0, 3) != 0);
            tx_mode_left = $urandom_range(10, 40);
        end
        tx_mode_left--;
        gap = tx_gappy ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({y, x, idx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic load_vertex(input int k, input coord_t x, input coord_t y);
        pv_x[k] = x;
        pv_y[k] = y;
        send_item(OP_LOAD, IDX_W'(k), x, y);
    endtask

    // vert_index is ignored for a test, so it carries random bits
    task automatic test_point(input coord_t x, input coord_t y);
        send_item(OP_TEST, IDX_W'($urandom()), x, y);
    endtask

    // new bounding box, then vertices for slots first..last-1 inside it
    task automatic load_polygon(input int first, input int last);
        case ($urandom_range(0, 2))
            0:       box_r = 64;
            1:       box_r = 2048;
            default: box_r = 32767;
        endcase
        box_cx = int'($urandom_range(0, 65535)) - 32768;
        box_cy = int'($urandom_range(0, 65535)) - 32768;
        for (int k = first; k < last; k++)
            load_vertex(k, near(box_cx, box_r), near(box_cy, box_r));
    endtask

    // mostly points around the polygon, some on its vertices or on the
    // horizontal and vertical lines through them, a few anywhere
    task automatic test_random_point(input int eff);
        int sel;
        int k;
        sel = $urandom_range(0, 19);
        k   = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
        if (sel < 13)
            test_point(near(box_cx, box_r), near(box_cy, box_r));
        else if (sel < 15)
            test_point(pv_x[k], pv_y[k]);
        else if (sel < 16)
            test_point(near(box_cx, box_r), pv_y[k]);
        else if (sel < 17)
            test_point(pv_x[k], near(box_cy, box_r));
        else
            test_point(coord_t'($urandom()), coord_t'($urandom()));
    endtask

    // drop valid, wait for every outstanding result, then let the block drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
        repeat (LAT_PAUSE) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic set_vertex_count(input int n);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(n);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // one vertex count: reprogram, (re)load the needed slots, then test points
    // with a few stray loads mixed in
    task automatic run_phase(input int n, input bit squeeze);
        int eff;
        int k;
        set_vertex_count(n);
        phases_run++;
        eff = (n > MAX_VERTS_DEF) ? MAX_VERTS_DEF : n;
        if (eff <= 16) begin
            load_polygon(0, eff);
        end else if (filled < eff) begin
            load_polygon(filled, eff);
        end else begin
            k = $urandom_range(0, eff - 8);
            load_polygon(k, k + 8);
        end
        if (eff > filled)
            filled = eff;
        // sender keeps offering tests while the result side is held off
        if (squeeze)
            hold_req = 1'b1;
        for (int t = 0; t < TESTS_PER_PHASE; t++) begin
            if ($urandom_range(0, 7) == 0)
                load_vertex($urandom_range(0, MAX_VERTS_DEF - 1),
                            coord_t'($urandom()), coord_t'($urandom()));
            test_random_point(eff);
        end
    endtask

    // main sequence
    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= OP_LOAD;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        hold_req     = 1'b0;
        tx_gappy     = 1;
        tx_mode_left = 0;
        phases_run   = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // small right triangle at the reset vertex count of three
        load_vertex(0, 16'sd0, 16'sd0);
        load_vertex(1, 16'sd160, 16'sd0);
        load_vertex(2, 16'sd0, 16'sd160);
        test_point(16'sd16, 16'sd16);         // inside
        test_point(16'sd200, 16'sd200);       // outside
        test_point(16'sd0, 16'sd0);           // on a vertex
        test_point(16'sd80, 16'sd0);          // on the bottom edge
        test_point(16'sd80, 16'sd80);         // on the slanted edge
        test_point(-16'sd32768, -16'sd32768); // coordinate extremes
        test_point(16'sd32767, 16'sd32767);
        test_point(-16'sd32768, 16'sd16);     // left of both crossings
        test_point(16'sd32767, 16'sd16);      // right of everything

        // full-range triangle: widest edge deltas and products
        load_vertex(0, -16'sd32768, -16'sd32768);
        load_vertex(1, 16'sd32767, -16'sd32768);
        load_vertex(2, 16'sd0, 16'sd32767);
        test_point(16'sd0, 16'sd0);
        test_point(-16'sd32768, -16'sd32768);
        test_point(16'sd32767, 16'sd32767);
        test_point(16'sd0, -16'sd32768);
        test_point(-16'sd32768, 16'sd0);
        filled = 3;

        // polygon sets per vertex count; the 64-vertex phase carries the stall
        for (int p = 0; p < N_PHASES; p++)
            run_phase(phase_counts[p], p == 1);

        settle();
        $display("covered %0d vertex loads and %0d point tests (%0d inside)",
                 chk_loads, chk_tests, chk_inside);
        $display("over %0d vertex count settings from 0 to 127, with a %0d-cycle result stall",
                 phases_run, HOLD_CYCLES);
        if (chk_errors == 0 && chk_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
